>>> sv/egws_pkg.sv
// Shared constants, types and the Gaussian lookup table for the ECG waveform synthesizer.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package egws_pkg;

  localparam int GAUSS_DEPTH = 256;
  localparam int TIME_BITS   = 13;

  localparam int IDX_W      = $clog2(GAUSS_DEPTH);
  localparam int CNT_W      = $clog2(IDX_W);
  localparam int LEN_W      = 10;
  localparam int AMP_W      = 16;
  localparam int BP_W       = 12;
  localparam int JIT_W      = 7;
  localparam int SAMPLE_W   = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int FAC_W      = 8;
  localparam int THR_W      = BP_W + FAC_W;
  localparam int BND_W      = LEN_W + 2;
  localparam int CMP_W      = (TIME_BITS > BND_W) ? TIME_BITS : BND_W;
  localparam int A_W        = LEN_W + 2;
  localparam int N_W        = A_W + IDX_W;
  localparam int G_W        = 16;
  localparam int PROD_W     = AMP_W + G_W + 1;
  localparam int ACC_W      = SAMPLE_W + 2;
  localparam int T100_W     = TIME_BITS + 7;
  localparam int TCMP_W     = (T100_W > THR_W) ? T100_W : THR_W;

  localparam logic [LEN_W-1:0]        P_LEN_RST       = 10'd20;
  localparam logic [LEN_W-1:0]        QRS_LEN_RST     = 10'd25;
  localparam logic [LEN_W-1:0]        T_LEN_RST       = 10'd40;
  localparam logic signed [AMP_W-1:0] P_AMP_RST       = 16'sd614;
  localparam logic signed [AMP_W-1:0] QRS_AMP_RST     = 16'sd4096;
  localparam logic signed [AMP_W-1:0] T_AMP_RST       = 16'sd1229;
  localparam logic [BP_W-1:0]         BEAT_PERIOD_RST = 12'd250;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_P_LEN,
    REG_QRS_LEN,
    REG_T_LEN,
    REG_P_AMP,
    REG_QRS_AMP,
    REG_T_AMP,
    REG_BEAT_PERIOD
  } cfg_reg_t;

  typedef enum logic [1:0] {
    WIN_NONE,
    WIN_P,
    WIN_QRS,
    WIN_T
  } win_t;

  typedef struct packed {
    logic load;
    logic thr;
    logic div_init;
    logic div_step;
    logic neg_term;
    logic rom;
    logic mul;
    logic acc;
    logic fin;
  } cmd_t;

  typedef struct packed {
    win_t win;
  } stat_t;

  typedef logic [G_W-1:0] gauss_rom_t [GAUSS_DEPTH];

  localparam logic [63:0] DEPTH_SQ = 64'(GAUSS_DEPTH) * 64'(GAUSS_DEPTH);
  localparam logic [63:0] Q31_ONE  = 64'd1 << 31;

  // Entry i holds exp(-x*x/2) with x = 4i/DEPTH in unsigned Q1.15, built from a short
  // series on x*x/512 that is then squared eight times.
  function automatic gauss_rom_t gauss_rom_build();
    gauss_rom_t  rom;
    logic [63:0] ii;
    logic [63:0] y;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] z3;
    logic [63:0] z4;
    logic [63:0] e;
    for (int i = 0; i < GAUSS_DEPTH; i++) begin
      ii = 64'(i);
      y  = ((64'd8 * ii * ii) << 31) / DEPTH_SQ;
      z  = y >> 8;
      z2 = (z * z) >> 31;
      z3 = (z2 * z) >> 31;
      z4 = (z3 * z) >> 31;
      e  = Q31_ONE - z + z2 / 64'd2 - z3 / 64'd6 + z4 / 64'd24;
      for (int k = 0; k < 8; k++) begin
        e = (e * e + (64'd1 << 30)) >> 31;
      end
      rom[i] = G_W'((e + (64'd1 << 15)) >> 16);
    end
    return rom;
  endfunction

  localparam gauss_rom_t GAUSS_ROM = gauss_rom_build();

endpackage

`default_nettype wire

>>> sv/egws_in_if.sv
// Input channel of the ECG waveform synthesizer: one sample tick with its jitter.
// Depends on egws_pkg for the field width.
`default_nettype none

interface egws_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [egws_pkg::JIT_W-1:0]  jitter_pct;

  modport source (output valid, output jitter_pct, input ready);
  modport sink (input valid, input jitter_pct, output ready);
endinterface

`default_nettype wire

>>> sv/egws_out_if.sv
// Result channel of the ECG waveform synthesizer: one saturated Q3.12 sample.
// Depends on egws_pkg for the field width.
`default_nettype none

interface egws_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [egws_pkg::SAMPLE_W-1:0] ecg_sample;

  modport source (output valid, output ecg_sample, input ready);
  modport sink (input valid, input ecg_sample, output ready);
endinterface

`default_nettype wire

>>> sv/egws_cfg_if.sv
// Configuration write channel of the ECG waveform synthesizer: register index and data.
// Depends on egws_pkg for the field widths.
`default_nettype none

interface egws_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [egws_pkg::CFG_IDX_W-1:0]    index;
  logic [egws_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> sv/ecg_gaussian_waveform_synth.sv
// Top level of the synthetic ECG Gaussian waveform synthesizer.
// Depends on egws_pkg, the three channel interfaces, egws_ctrl, egws_dp and egws_div.
//
// Each transfer on in_ch is one sample tick carrying a jitter percentage; each tick
// produces exactly one transfer on out_ch with the summed, saturated Q3.12 sample.
// Registers are written on cfg_ch by index (0 p_len .. 6 beat_period); the user must
// write them only while idle, which the block does not enforce; cfg_ch is always ready.
// One tick at a time is processed. Outside the waveform windows a tick goes from the
// input transfer through the threshold step to the result; the P or T window evaluates
// one Gaussian and the QRS window two. Each Gaussian costs one bit-per-cycle division
// plus table read, multiply and accumulate. in_ready rises again in the cycle after
// the result is registered, so a new tick can be taken while that result still waits
// on out_ch.
// Reset (rst_n low, synchronous) restores the default registers, clears the
// time-in-beat counter and empties the output register. If the receiver stalls, the
// result is held on out_ch and the next tick stops just before its result is written.
`default_nettype none

module ecg_gaussian_waveform_synth (
  input  wire logic    clk,
  input  wire logic    rst_n,
  egws_in_if.sink      in_ch,
  egws_out_if.source   out_ch,
  egws_cfg_if.sink     cfg_ch
);

  egws_pkg::cmd_t  cmd;
  egws_pkg::stat_t status;

  assign cfg_ch.ready = 1'b1;

  egws_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  egws_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg_we     (cfg_ch.valid),
    .cfg_index  (cfg_ch.index),
    .cfg_data   (cfg_ch.data),
    .in_jitter  (in_ch.jitter_pct),
    .status     (status),
    .out_sample (out_ch.ecg_sample)
  );

endmodule

`default_nettype wire

>>> sv/egws_div.sv
// Restoring divider that turns elapsed time over half-width into a Gaussian table index.
// One quotient bit per step; depends on egws_pkg.
`default_nettype none

module egws_div (
  input  wire logic                          clk,
  input  wire logic                          init,
  input  wire logic                          step,
  input  wire logic [egws_pkg::A_W-1:0]      num,
  input  wire logic [egws_pkg::A_W-1:0]      den4,
  output logic      [egws_pkg::IDX_W-1:0]    idx
);

  logic [egws_pkg::N_W-1:0]   rem_r;
  logic [egws_pkg::N_W-1:0]   dsh_r;
  logic [egws_pkg::IDX_W-1:0] q_r;
  logic                       sat_r;

  always_ff @(posedge clk) begin
    if (init) begin
      rem_r <= egws_pkg::N_W'(num) * egws_pkg::N_W'(egws_pkg::GAUSS_DEPTH);
      dsh_r <= egws_pkg::N_W'(den4) << (egws_pkg::IDX_W - 1);
      q_r   <= '0;
      sat_r <= (num >= den4);
    end else if (step) begin
      if (rem_r >= dsh_r) begin
        rem_r <= rem_r - dsh_r;
        q_r   <= {q_r[egws_pkg::IDX_W-2:0], 1'b1};
      end else begin
        q_r   <= {q_r[egws_pkg::IDX_W-2:0], 1'b0};
      end
      dsh_r <= dsh_r >> 1;
    end
  end

  assign idx = sat_r ? egws_pkg::IDX_W'(egws_pkg::GAUSS_DEPTH - 1) : q_r;

endmodule

`default_nettype wire

>>> sv/egws_dp.sv
// Datapath of the ECG waveform synthesizer: registers, window select, divider, table,
// multiplier, accumulator and beat counter. Depends on egws_pkg and egws_div.
`default_nettype none

module egws_dp (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire egws_pkg::cmd_t                         cmd,
  input  wire logic                                   cfg_we,
  input  wire logic [egws_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [egws_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  wire logic signed [egws_pkg::JIT_W-1:0]      in_jitter,
  output egws_pkg::stat_t                             status,
  output logic signed [egws_pkg::SAMPLE_W-1:0]        out_sample
);

  localparam logic signed [egws_pkg::ACC_W-1:0] SAMPLE_MAX =
    egws_pkg::ACC_W'((1 << (egws_pkg::SAMPLE_W - 1)) - 1);
  localparam logic signed [egws_pkg::ACC_W-1:0] SAMPLE_MIN = -SAMPLE_MAX - 1;

  logic [egws_pkg::LEN_W-1:0]                p_len_r, qrs_len_r, t_len_r;
  logic signed [egws_pkg::AMP_W-1:0]         p_amp_r, qrs_amp_r, t_amp_r;
  logic [egws_pkg::BP_W-1:0]                 beat_period_r;
  logic [egws_pkg::TIME_BITS-1:0]            tib_r, tib_nxt;
  logic signed [egws_pkg::JIT_W-1:0]         jit_r;
  egws_pkg::win_t                            win_r, win_nxt;
  logic [egws_pkg::LEN_W-1:0]                off_r, off_nxt;
  logic [egws_pkg::THR_W-1:0]                thr_r;
  logic [egws_pkg::G_W-1:0]                  g_r;
  logic signed [egws_pkg::PROD_W-1:0]        prod_r, prod_nxt;
  logic signed [egws_pkg::ACC_W-1:0]         acc_r, acc_nxt;
  logic signed [egws_pkg::SAMPLE_W-1:0]      out_r;

  logic [egws_pkg::CMP_W-1:0]                t_ext, b1, b2, b3;
  logic [egws_pkg::CMP_W-1:0]                d_q, d_t;
  logic [egws_pkg::LEN_W-1:0]                den_sel;
  logic signed [egws_pkg::AMP_W-1:0]         amp_sel;
  logic [egws_pkg::A_W-1:0]                  two_off, four_off, two_ql, num_sel, den4;
  logic [egws_pkg::IDX_W-1:0]                idx;
  logic [8:0]                                fac_w;
  logic signed [egws_pkg::PROD_W-1:0]        amp_x, g_x;
  logic signed [egws_pkg::PROD_W:0]          prod_x, pos_t, neg_t, term;
  logic [egws_pkg::TIME_BITS-1:0]            tib_inc;
  logic [egws_pkg::T100_W-1:0]               tib100;

  always_comb begin
    t_ext = egws_pkg::CMP_W'(tib_r);
    b1    = egws_pkg::CMP_W'(p_len_r);
    b2    = b1 + egws_pkg::CMP_W'(qrs_len_r);
    b3    = b2 + egws_pkg::CMP_W'(t_len_r);
    d_q   = t_ext - b1;
    d_t   = t_ext - b2;
    if (t_ext < b1) begin
      win_nxt = egws_pkg::WIN_P;
      off_nxt = t_ext[egws_pkg::LEN_W-1:0];
    end else if (t_ext < b2) begin
      win_nxt = egws_pkg::WIN_QRS;
      off_nxt = d_q[egws_pkg::LEN_W-1:0];
    end else if (t_ext < b3) begin
      win_nxt = egws_pkg::WIN_T;
      off_nxt = d_t[egws_pkg::LEN_W-1:0];
    end else begin
      win_nxt = egws_pkg::WIN_NONE;
      off_nxt = '0;
    end
  end

  always_comb begin
    case (win_r)
      egws_pkg::WIN_QRS: begin
        den_sel = qrs_len_r;
        amp_sel = qrs_amp_r;
      end
      egws_pkg::WIN_T: begin
        den_sel = t_len_r;
        amp_sel = t_amp_r;
      end
      default: begin
        den_sel = p_len_r;
        amp_sel = p_amp_r;
      end
    endcase
    two_off  = egws_pkg::A_W'({off_r, 1'b0});
    four_off = {off_r, 2'b00};
    two_ql   = egws_pkg::A_W'({qrs_len_r, 1'b0});
    den4     = {den_sel, 2'b00};
    if (win_r == egws_pkg::WIN_QRS) begin
      if (!cmd.neg_term) begin
        num_sel = four_off;
      end else if (four_off >= two_ql) begin
        num_sel = four_off - two_ql;
      end else begin
        num_sel = two_ql - four_off;
      end
    end else begin
      num_sel = two_off;
    end
  end

  egws_div u_div (
    .clk  (clk),
    .init (cmd.div_init),
    .step (cmd.div_step),
    .num  (num_sel),
    .den4 (den4),
    .idx  (idx)
  );

  always_comb begin
    fac_w    = 9'd100 + {{2{jit_r[egws_pkg::JIT_W-1]}}, jit_r};
    amp_x    = egws_pkg::PROD_W'(amp_sel);
    g_x      = $signed(egws_pkg::PROD_W'(g_r));
    prod_nxt = amp_x * g_x;
    prod_x   = {prod_r[egws_pkg::PROD_W-1], prod_r};
    pos_t    = (prod_x + $signed((egws_pkg::PROD_W + 1)'(1 << 14))) >>> 15;
    neg_t    = (-prod_x + $signed((egws_pkg::PROD_W + 1)'(1 << 15))) >>> 16;
    term     = cmd.neg_term ? neg_t : pos_t;
    acc_nxt  = acc_r + $signed(term[egws_pkg::ACC_W-1:0]);
    tib_inc  = tib_r + egws_pkg::TIME_BITS'(1);
    tib100   = egws_pkg::T100_W'(tib_inc) * egws_pkg::T100_W'(100);
    if (egws_pkg::TCMP_W'(tib100) >= egws_pkg::TCMP_W'(thr_r)) begin
      tib_nxt = '0;
    end else begin
      tib_nxt = tib_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_len_r       <= egws_pkg::P_LEN_RST;
      qrs_len_r     <= egws_pkg::QRS_LEN_RST;
      t_len_r       <= egws_pkg::T_LEN_RST;
      p_amp_r       <= egws_pkg::P_AMP_RST;
      qrs_amp_r     <= egws_pkg::QRS_AMP_RST;
      t_amp_r       <= egws_pkg::T_AMP_RST;
      beat_period_r <= egws_pkg::BEAT_PERIOD_RST;
      tib_r         <= '0;
      win_r         <= egws_pkg::WIN_NONE;
    end else begin
      if (cfg_we) begin
        case (egws_pkg::cfg_reg_t'(cfg_index))
          egws_pkg::REG_P_LEN:       p_len_r       <= cfg_data[egws_pkg::LEN_W-1:0];
          egws_pkg::REG_QRS_LEN:     qrs_len_r     <= cfg_data[egws_pkg::LEN_W-1:0];
          egws_pkg::REG_T_LEN:       t_len_r       <= cfg_data[egws_pkg::LEN_W-1:0];
          egws_pkg::REG_P_AMP:       p_amp_r       <= $signed(cfg_data);
          egws_pkg::REG_QRS_AMP:     qrs_amp_r     <= $signed(cfg_data);
          egws_pkg::REG_T_AMP:       t_amp_r       <= $signed(cfg_data);
          egws_pkg::REG_BEAT_PERIOD: beat_period_r <= cfg_data[egws_pkg::BP_W-1:0];
          default: begin
          end
        endcase
      end
      if (cmd.load) begin
        win_r <= win_nxt;
      end
      if (cmd.fin) begin
        tib_r <= tib_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      jit_r <= in_jitter;
      off_r <= off_nxt;
      acc_r <= '0;
    end
    if (cmd.thr) begin
      thr_r <= egws_pkg::THR_W'(beat_period_r) * egws_pkg::THR_W'(fac_w[egws_pkg::FAC_W-1:0]);
    end
    if (cmd.rom) begin
      g_r <= egws_pkg::GAUSS_ROM[idx];
    end
    if (cmd.mul) begin
      prod_r <= prod_nxt;
    end
    if (cmd.acc) begin
      acc_r <= acc_nxt;
    end
    if (cmd.fin) begin
      if (acc_r > SAMPLE_MAX) begin
        out_r <= SAMPLE_MAX[egws_pkg::SAMPLE_W-1:0];
      end else if (acc_r < SAMPLE_MIN) begin
        out_r <= SAMPLE_MIN[egws_pkg::SAMPLE_W-1:0];
      end else begin
        out_r <= acc_r[egws_pkg::SAMPLE_W-1:0];
      end
    end
  end

  assign status.win = win_r;
  assign out_sample = out_r;

endmodule

`default_nettype wire

>>> sv/egws_ctrl.sv
// Controller of the ECG waveform synthesizer: sequences one sample through the datapath
// and owns the channel handshakes. Depends on egws_pkg.
`default_nettype none

module egws_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire egws_pkg::stat_t    status,
  output egws_pkg::cmd_t          cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_THR,
    S_INIT,
    S_DIV,
    S_ROM,
    S_MUL,
    S_ACC,
    S_FIN
  } state_t;

  state_t                     state_r;
  logic                       out_valid_r;
  logic                       term_r;
  logic [egws_pkg::CNT_W-1:0] cnt_r;

  always_comb begin
    cmd          = '0;
    cmd.neg_term = term_r;
    case (state_r)
      S_IDLE:  cmd.load     = in_valid;
      S_THR:   cmd.thr      = 1'b1;
      S_INIT:  cmd.div_init = 1'b1;
      S_DIV:   cmd.div_step = 1'b1;
      S_ROM:   cmd.rom      = 1'b1;
      S_MUL:   cmd.mul      = 1'b1;
      S_ACC:   cmd.acc      = 1'b1;
      S_FIN:   cmd.fin      = !out_valid_r || out_ready;
      default: begin
      end
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      term_r      <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (cmd.fin) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            term_r  <= 1'b0;
            state_r <= S_THR;
          end
        end
        S_THR: begin
          if (status.win == egws_pkg::WIN_NONE) begin
            state_r <= S_FIN;
          end else begin
            state_r <= S_INIT;
          end
        end
        S_INIT: begin
          cnt_r   <= egws_pkg::CNT_W'(egws_pkg::IDX_W - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          cnt_r <= cnt_r - egws_pkg::CNT_W'(1);
          if (cnt_r == '0) begin
            state_r <= S_ROM;
          end
        end
        S_ROM: state_r <= S_MUL;
        S_MUL: state_r <= S_ACC;
        S_ACC: begin
          if (status.win == egws_pkg::WIN_QRS && !term_r) begin
            term_r  <= 1'b1;
            state_r <= S_INIT;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (cmd.fin) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.thr, cmd.div_init, cmd.div_step, cmd.rom, cmd.mul,
              cmd.acc, cmd.fin}))
    else $error("more than one datapath command active");
  a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> out_valid_r)
    else $error("finished sample not presented");
  a_fin_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |-> (!out_valid_r || out_ready))
    else $error("pending sample overwritten");
  a_neg_qrs: assert property (@(posedge clk) disable iff (!rst_n)
    (term_r && state_r != S_IDLE) |-> (status.win == egws_pkg::WIN_QRS))
    else $error("second term outside the QRS window");
`endif

endmodule

`default_nettype wire

>>> sim/ecg_gaussian_waveform_synth_tb.sv
// Self-checking testbench for ecg_gaussian_waveform_synth: sample ticks with random jitter,
// bursty input, a stalling receiver and register changes between phases.
// Depends on egws_pkg and the egws_in_if, egws_out_if and egws_cfg_if interfaces.
module ecg_gaussian_waveform_synth_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import egws_pkg::*;

  localparam int RANDOM_TICKS  = 950;
  localparam int SETTLE_CYCLES = 32;
  localparam logic [CFG_IDX_W-1:0] IDX_UNMAPPED = 3'd7;

  logic clk;
  logic rst_n;

  egws_in_if  in_ch ();
  egws_out_if out_ch ();
  egws_cfg_if cfg_ch ();

  ecg_gaussian_waveform_synth dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predicted register file and time-in-beat counter.
  logic [LEN_W-1:0]        p_len_m, qrs_len_m, t_len_m;
  logic signed [AMP_W-1:0] p_amp_m, qrs_amp_m, t_amp_m;
  logic [BP_W-1:0]         beat_period_m;
  logic [TIME_BITS-1:0]    beat_time;
  logic [G_W-1:0]          gauss_lut [GAUSS_DEPTH];

  logic signed [JIT_W-1:0]    tick_q [$];
  logic signed [SAMPLE_W-1:0] sample_q [$];

  int  n_errors;
  int  n_ticks;
  int  n_checked;
  int  n_writes;
  int  n_settings;
  int  burst_left;
  int  gap_left;
  int  stall_left;
  bit  steady_in;
  bit  steady_out;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("ecg_gaussian_waveform_synth_tb: done, errors");
    $finish;
  end

  function automatic logic [G_W-1:0] gauss_entry(input int i);
    logic [63:0] sq, y, z, z2, z3, z4, e;
    sq = 64'(i) * 64'(i);
    y  = (sq << 34) / (64'(GAUSS_DEPTH) * 64'(GAUSS_DEPTH));
    z  = y >> 8;
    z2 = (z * z) >> 31;
    z3 = (z2 * z) >> 31;
    z4 = (z3 * z) >> 31;
    e  = (64'd1 << 31) - z + z2 / 64'd2 - z3 / 64'd6 + z4 / 64'd24;
    repeat (8) e = (e * e + (64'd1 << 30)) >> 31;
    return G_W'((e + (64'd1 << 15)) >> 16);
  endfunction

  function automatic longint gauss_at(input longint num, input longint den);
    longint mag, idx;
    mag = (num < 0) ? -num : num;
    idx = (mag * GAUSS_DEPTH) / (4 * den);
    if (idx > GAUSS_DEPTH - 1) idx = GAUSS_DEPTH - 1;
    return longint'(gauss_lut[idx]);
  endfunction

  function automatic longint round_down_shift(input longint x, input int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  task automatic synth_sample(input logic signed [JIT_W-1:0] jit,
                              output logic signed [SAMPLE_W-1:0] smp);
    longint t, pl, ql, tl, r, acc, thr;
    t   = longint'(beat_time);
    pl  = longint'(p_len_m);
    ql  = longint'(qrs_len_m);
    tl  = longint'(t_len_m);
    acc = 0;
    if (t < pl) begin
      acc = round_down_shift(longint'(p_amp_m) * gauss_at(2 * t, pl), 15);
    end else if (t < pl + ql) begin
      r   = t - pl;
      acc = round_down_shift(longint'(qrs_amp_m) * gauss_at(4 * r, ql), 15);
      acc += round_down_shift(-longint'(qrs_amp_m) * gauss_at(4 * r - 2 * ql, ql), 16);
    end else if (t < pl + ql + tl) begin
      r   = t - pl - ql;
      acc = round_down_shift(longint'(t_amp_m) * gauss_at(2 * r, tl), 15);
    end
    if (acc > 32767) acc = 32767;
    else if (acc < -32768) acc = -32768;
    smp = acc[SAMPLE_W-1:0];
    beat_time = beat_time + 1'b1;
    thr = longint'(beat_period_m) * (100 + longint'(jit));
    if (longint'(beat_time) * 100 >= thr) beat_time = '0;
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_P_LEN:       p_len_m = d[LEN_W-1:0];
      REG_QRS_LEN:     qrs_len_m = d[LEN_W-1:0];
      REG_T_LEN:       t_len_m = d[LEN_W-1:0];
      REG_P_AMP:       p_amp_m = d;
      REG_QRS_AMP:     qrs_amp_m = d;
      REG_T_AMP:       t_amp_m = d;
      REG_BEAT_PERIOD: beat_period_m = d[BP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic flag_error(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    n_writes++;
  endtask

  task automatic wait_drained();
    while (tick_q.size() != 0 || in_ch.valid || sample_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_len();
    int r;
    logic [LEN_W-1:0] len;
    r = $urandom_range(0, 99);
    if (r < 8) len = '0;
    else if (r < 16) len = 10'd1;
    else if (r < 20) len = 10'd1023;
    else if (r < 24) len = LEN_W'($urandom_range(100, 1022));
    else len = LEN_W'($urandom_range(2, 40));
    return {6'($urandom()), len};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_amp();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'h8000;
    if (r < 20) return 16'h7fff;
    if (r < 25) return 16'h0000;
    return 16'($urandom());
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_period();
    int r;
    logic [BP_W-1:0] bp;
    r = $urandom_range(0, 99);
    if (r < 5) bp = '0;
    else if (r < 10) bp = 12'd4095;
    else if (r < 15) bp = 12'd1;
    else if (r < 20) bp = BP_W'($urandom_range(300, 4094));
    else bp = BP_W'($urandom_range(2, 150));
    return {4'($urandom()), bp};
  endfunction

  function automatic logic signed [JIT_W-1:0] rand_jitter();
    if ($urandom_range(0, 99) < 85) return JIT_W'(int'($urandom_range(0, 99)) - 50);
    return JIT_W'($urandom());
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (tick_q.size() != 0) begin
        in_ch.valid      <= 1'b1;
        in_ch.jitter_pct <= tick_q.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else if (!steady_in) begin
          burst_left = $urandom_range(0, 12);
          gap_left   = $urandom_range(0, 20);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver, predictor and checker.
  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) apply_reg(cfg_ch.index, cfg_ch.data);
      if (in_ch.valid && in_ch.ready) begin
        synth_sample(in_ch.jitter_pct, want);
        sample_q.push_back(want);
        n_ticks++;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (sample_q.size() == 0) begin
          flag_error($sformatf("unexpected sample %0d", out_ch.ecg_sample));
        end else begin
          want = sample_q.pop_front();
          if (out_ch.ecg_sample !== want)
            flag_error($sformatf("sample %0d: expected %0d, got %0d",
                                 n_checked, want, out_ch.ecg_sample));
          n_checked++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!steady_out && $urandom_range(0, 99) < 25) stall_left = $urandom_range(1, 30);
      end
    end
  end

  initial begin
    int n_random;
    int n_phase;
    in_ch.valid       = 1'b0;
    in_ch.jitter_pct  = '0;
    out_ch.ready      = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = '0;
    cfg_ch.data       = '0;
    rst_n             = 1'b0;
    for (int i = 0; i < GAUSS_DEPTH; i++) gauss_lut[i] = gauss_entry(i);
    p_len_m       = P_LEN_RST;
    qrs_len_m     = QRS_LEN_RST;
    t_len_m       = T_LEN_RST;
    p_amp_m       = P_AMP_RST;
    qrs_amp_m     = QRS_AMP_RST;
    t_amp_m       = T_AMP_RST;
    beat_period_m = BEAT_PERIOD_RST;
    beat_time     = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Reset defaults with the jitter extremes, in range and out of range.
    n_settings = 1;
    tick_q.push_back(7'sd0);
    tick_q.push_back(-7'sd50);
    tick_q.push_back(7'sd49);
    tick_q.push_back(-7'sd64);
    tick_q.push_back(7'sd63);
    wait_drained();

    // Short windows and full-scale amplitudes; the beats pass through the P and QRS windows.
    write_reg(REG_P_LEN, 16'hfc02);
    write_reg(REG_QRS_LEN, 16'h0006);
    write_reg(REG_T_LEN, 16'h0003);
    write_reg(REG_P_AMP, 16'h7fff);
    write_reg(REG_QRS_AMP, 16'h8000);
    write_reg(REG_T_AMP, 16'h7fff);
    write_reg(REG_BEAT_PERIOD, 16'hf00a);
    write_reg(IDX_UNMAPPED, 16'hffff);
    n_settings++;
    for (int i = 0; i < 14; i++) tick_q.push_back((i % 3 == 0) ? -7'sd50 : 7'sd0);
    wait_drained();

    // Empty P and T windows with a zero beat period, then an empty QRS window as well.
    write_reg(REG_P_LEN, 16'h0000);
    write_reg(REG_T_LEN, 16'h0000);
    write_reg(REG_QRS_LEN, 16'h0003);
    write_reg(REG_BEAT_PERIOD, 16'h0000);
    n_settings++;
    repeat (4) tick_q.push_back(rand_jitter());
    wait_drained();
    write_reg(REG_QRS_LEN, 16'h0400);
    n_settings++;
    repeat (2) tick_q.push_back(rand_jitter());
    wait_drained();

    n_random = 0;
    while (n_random < RANDOM_TICKS) begin
      write_reg(REG_P_LEN, pick_len());
      write_reg(REG_QRS_LEN, pick_len());
      write_reg(REG_T_LEN, pick_len());
      write_reg(REG_P_AMP, pick_amp());
      write_reg(REG_QRS_AMP, pick_amp());
      write_reg(REG_T_AMP, pick_amp());
      write_reg(REG_BEAT_PERIOD, pick_period());
      if ($urandom_range(0, 3) == 0) write_reg(IDX_UNMAPPED, 16'($urandom()));
      n_settings++;
      steady_in  = ($urandom_range(0, 3) == 0);
      steady_out = ($urandom_range(0, 3) == 0);
      n_phase = $urandom_range(40, 120);
      repeat (n_phase) tick_q.push_back(rand_jitter());
      n_random += n_phase;
      wait_drained();
    end

    if (sample_q.size() != 0) flag_error($sformatf("%0d samples never arrived", sample_q.size()));
    $display("%0d sample ticks sent, %0d samples checked", n_ticks, n_checked);
    $display("%0d register settings, %0d register writes, %0d errors",
             n_settings, n_writes, n_errors);
    if (n_errors == 0) begin
      $display("ecg_gaussian_waveform_synth_tb: done, clean");
    end else begin
      $display("ecg_gaussian_waveform_synth_tb: done, errors");
    end
    $finish;
  end

endmodule
